### hdl/edit_log_stream_checker_top_defines.svh
// assertion macros for the edit-log stream checker
`ifndef EDIT_LOG_STREAM_CHECKER_TOP_DEFINES_SVH
`define EDIT_LOG_STREAM_CHECKER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define ELSC_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("elsc assertion failed");
`define ELSC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("elsc assertion failed");
`else
`define ELSC_ASSERT_IMPLY(lbl, ante, cons)
`define ELSC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### hdl/elsc_pkg.sv
package elsc_pkg;

	localparam int HEADER_BYTES = 20;
	localparam int REC_LEN = 16;
	localparam int POS_W = 37;
	localparam int SLOT_W = $clog2(REC_LEN);
	localparam int HDR_POS_W = $clog2(HEADER_BYTES);
	localparam int CFG_ADDR_W = 4;

	// header offsets
	localparam logic [HDR_POS_W-1:0] OFS_VERSION = HDR_POS_W'(4);
	localparam logic [HDR_POS_W-1:0] OFS_RESERVED_END = HDR_POS_W'(8);
	localparam logic [HDR_POS_W-1:0] OFS_SEED_END = HDR_POS_W'(12);
	localparam logic [HDR_POS_W-1:0] OFS_COUNT_END = HDR_POS_W'(16);
	localparam logic [HDR_POS_W-1:0] OFS_MAGIC_END = HDR_POS_W'(4);

	// "VLOG" little-endian, byte 0 in the low lane
	localparam logic [31:0] MAGIC_WORD = 32'h474F_4C56;
	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

	typedef enum logic [3:0] {
		V_OK        = 4'd0,
		V_SHORT     = 4'd1,
		V_MAGIC     = 4'd2,
		V_VERSION   = 4'd3,
		V_RESERVED  = 4'd4,
		V_SEED      = 4'd5,
		V_LENGTH    = 4'd6,
		V_CRC       = 4'd7,
		V_ZERO_TICK = 4'd8,
		V_ORDER     = 4'd9,
		V_BLOCK_ID  = 4'd10,
		V_NO_CHANGE = 4'd11,
		V_PAD       = 4'd12
	} verdict_t;

	typedef enum logic [1:0] {
		REG_SEED      = 2'd0,
		REG_VERSION   = 2'd1,
		REG_MAX_BLOCK = 2'd2
	} cfg_reg_t;

	// reflected crc-32, one byte
	function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			r = (r >> 1) ^ (CRC_POLY & {32{r[0]}});
		end
		return r;
	endfunction

endpackage

### hdl/elsc_in_if.sv
interface elsc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, in_byte, in_last, input ready);
	modport sink (input valid, in_byte, in_last, output ready);
endinterface

### hdl/elsc_out_if.sv
interface elsc_out_if;
	logic               valid;
	logic               ready;
	logic        [31:0] rec_tick;
	logic signed [31:0] rec_x;
	logic signed [31:0] rec_z;
	logic        [7:0]  rec_height;
	logic        [7:0]  rec_prev_block;
	logic        [7:0]  rec_next_block;
	logic               record_ready;
	logic               stream_done;
	logic        [3:0]  verdict;

	modport source (output valid, rec_tick, rec_x, rec_z, rec_height, rec_prev_block,
		rec_next_block, record_ready, stream_done, verdict, input ready);
	modport sink (input valid, rec_tick, rec_x, rec_z, rec_height, rec_prev_block,
		rec_next_block, record_ready, stream_done, verdict, output ready);
endinterface

### hdl/edit_log_stream_checker_top.sv
// a byte is accepted into the input register; any result it gives loads the result register
// when the byte advances, which waits while a held result is not yet taken by the output
// throughput: one byte per cycle unless a result waits for the output; byte-wide crc and field
// checks sit in one stage; a byte that gives no result never waits on the output side
// reset: arst_n clears stream state, handshake state and the configuration registers to their defaults
// after each final byte the stream state returns to its reset values
`include "edit_log_stream_checker_top_defines.svh"

module edit_log_stream_checker_top (
	input  logic                            clk,
	input  logic                            arst_n,
	elsc_in_if.sink                         in_ch,
	elsc_out_if.source                      out_ch,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [elsc_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);

	localparam int POS_W = elsc_pkg::POS_W;
	localparam int SLOT_W = elsc_pkg::SLOT_W;
	localparam int HP_W = elsc_pkg::HDR_POS_W;
	localparam int REC_LEN = elsc_pkg::REC_LEN;

	// configuration
	logic [31:0] seed_q;
	logic [7:0]  version_q;
	logic [7:0]  max_block_q;
	elsc_pkg::cfg_reg_t cfg_sel;

	assign cfg_sel = elsc_pkg::cfg_reg_t'(paddr[3:2]);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= 32'd0;
			version_q <= 8'd1;
			max_block_q <= 8'hFF;
		end else if (psel && penable && pwrite) begin
			unique case (cfg_sel)
				elsc_pkg::REG_SEED: seed_q <= pwdata;
				elsc_pkg::REG_VERSION: version_q <= pwdata[7:0];
				elsc_pkg::REG_MAX_BLOCK: max_block_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_sel)
			elsc_pkg::REG_SEED: prdata = seed_q;
			elsc_pkg::REG_VERSION: prdata = {24'd0, version_q};
			elsc_pkg::REG_MAX_BLOCK: prdata = {24'd0, max_block_q};
			default: prdata = 32'd0;
		endcase
	end

	// input register
	logic       v_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       adv_s1;
	logic       has_result;
	logic       out_free;

	assign out_free = !out_ch.valid || out_ch.ready;
	assign adv_s1 = v_s1 && (!has_result || out_free);
	assign in_ch.ready = !v_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			v_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			byte_s1 <= in_ch.in_byte;
			last_s1 <= in_ch.in_last;
		end
	end

	// stream state
	logic [POS_W-1:0] pos_q, pos_d;
	logic [31:0]      count_q, count_d;
	logic [31:0]      stored_q, stored_d;
	logic [31:0]      crc_q, crc_d;
	logic [31:0]      prev_tick_q, prev_tick_d;
	elsc_pkg::verdict_t hfault_q, hfault_d;
	elsc_pkg::verdict_t rfault_q, rfault_d;
	logic [7:0]       rec_q [REC_LEN-1];

	logic              pos_sat;
	logic              in_hdr;
	logic [HP_W-1:0]   hp;
	logic [1:0]        lane;
	logic [SLOT_W-1:0] slot;
	logic              rec_we;
	logic              emit;
	elsc_pkg::verdict_t hcode;
	elsc_pkg::verdict_t fcode;
	elsc_pkg::verdict_t verdict;
	logic [31:0]       tick;
	logic [31:0]       rx;
	logic [31:0]       rz;
	logic [POS_W-1:0]  len_expect;

	assign pos_sat = &pos_q;
	assign in_hdr = pos_q < POS_W'(elsc_pkg::HEADER_BYTES);
	assign hp = pos_q[HP_W-1:0];
	assign lane = pos_q[1:0];
	assign slot = SLOT_W'(pos_q - POS_W'(elsc_pkg::HEADER_BYTES));

	assign tick = {rec_q[3], rec_q[2], rec_q[1], rec_q[0]};
	assign rx = {rec_q[7], rec_q[6], rec_q[5], rec_q[4]};
	assign rz = {rec_q[11], rec_q[10], rec_q[9], rec_q[8]};

	always_comb begin
		priority if (tick == 32'd0) fcode = elsc_pkg::V_ZERO_TICK;
		else if (tick < prev_tick_q) fcode = elsc_pkg::V_ORDER;
		else if (rec_q[13] > max_block_q || rec_q[14] > max_block_q)
			fcode = elsc_pkg::V_BLOCK_ID;
		else if (rec_q[13] == rec_q[14]) fcode = elsc_pkg::V_NO_CHANGE;
		else if (byte_s1 != 8'd0) fcode = elsc_pkg::V_PAD;
		else fcode = elsc_pkg::V_OK;
	end

	always_comb begin
		priority if (hp < elsc_pkg::OFS_MAGIC_END) begin
			hcode = (byte_s1 != elsc_pkg::MAGIC_WORD[{lane, 3'b000} +: 8]) ?
				elsc_pkg::V_MAGIC : elsc_pkg::V_OK;
		end else if (hp == elsc_pkg::OFS_VERSION) begin
			hcode = (byte_s1 != version_q) ? elsc_pkg::V_VERSION : elsc_pkg::V_OK;
		end else if (hp < elsc_pkg::OFS_RESERVED_END) begin
			hcode = (byte_s1 != 8'd0) ? elsc_pkg::V_RESERVED : elsc_pkg::V_OK;
		end else if (hp < elsc_pkg::OFS_SEED_END) begin
			hcode = (byte_s1 != seed_q[{lane, 3'b000} +: 8]) ? elsc_pkg::V_SEED : elsc_pkg::V_OK;
		end else begin
			hcode = elsc_pkg::V_OK;
		end
	end

	always_comb begin
		pos_d = pos_q;
		count_d = count_q;
		stored_d = stored_q;
		crc_d = crc_q;
		prev_tick_d = prev_tick_q;
		hfault_d = hfault_q;
		rfault_d = rfault_q;
		rec_we = 1'b0;
		emit = 1'b0;
		if (!pos_sat) begin
			pos_d = pos_q + POS_W'(1);
			if (in_hdr) begin
				if (hfault_q == elsc_pkg::V_OK) hfault_d = hcode;
				if (hp < elsc_pkg::OFS_COUNT_END) begin
					crc_d = elsc_pkg::crc_byte(crc_q, byte_s1);
					if (hp >= elsc_pkg::OFS_SEED_END) count_d[{lane, 3'b000} +: 8] = byte_s1;
				end else begin
					stored_d[{lane, 3'b000} +: 8] = byte_s1;
				end
			end else begin
				crc_d = elsc_pkg::crc_byte(crc_q, byte_s1);
				if (slot == SLOT_W'(REC_LEN - 1)) begin
					if (fcode != elsc_pkg::V_OK) begin
						if (rfault_q == elsc_pkg::V_OK) rfault_d = fcode;
					end else if (rfault_q == elsc_pkg::V_OK) begin
						prev_tick_d = tick;
						emit = (hfault_q == elsc_pkg::V_OK);
					end
				end else begin
					rec_we = 1'b1;
				end
			end
		end
	end

	assign len_expect = POS_W'(elsc_pkg::HEADER_BYTES) + POS_W'({count_d, {SLOT_W{1'b0}}});

	always_comb begin
		priority if (pos_d < POS_W'(elsc_pkg::HEADER_BYTES)) verdict = elsc_pkg::V_SHORT;
		else if (hfault_d != elsc_pkg::V_OK) verdict = hfault_d;
		else if (pos_d != len_expect) verdict = elsc_pkg::V_LENGTH;
		else if (~crc_d != stored_d) verdict = elsc_pkg::V_CRC;
		else verdict = rfault_d;
	end

	assign has_result = emit || last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			count_q <= 32'd0;
			stored_q <= 32'd0;
			crc_q <= 32'hFFFF_FFFF;
			prev_tick_q <= 32'd0;
			hfault_q <= elsc_pkg::V_OK;
			rfault_q <= elsc_pkg::V_OK;
		end else if (adv_s1) begin
			if (last_s1) begin
				// verdict given, next byte opens a new stream
				pos_q <= '0;
				count_q <= 32'd0;
				stored_q <= 32'd0;
				crc_q <= 32'hFFFF_FFFF;
				prev_tick_q <= 32'd0;
				hfault_q <= elsc_pkg::V_OK;
				rfault_q <= elsc_pkg::V_OK;
			end else begin
				pos_q <= pos_d;
				count_q <= count_d;
				stored_q <= stored_d;
				crc_q <= crc_d;
				prev_tick_q <= prev_tick_d;
				hfault_q <= hfault_d;
				rfault_q <= rfault_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && rec_we) begin
			rec_q[slot] <= byte_s1;
		end
	end

	// result register
	logic               out_valid_q;
	logic        [31:0] o_tick_q;
	logic signed [31:0] o_x_q;
	logic signed [31:0] o_z_q;
	logic        [7:0]  o_height_q;
	logic        [7:0]  o_prev_q;
	logic        [7:0]  o_next_q;
	logic               o_rec_q;
	logic               o_done_q;
	elsc_pkg::verdict_t o_verdict_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && has_result) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && has_result) begin
			o_tick_q <= emit ? tick : 32'd0;
			o_x_q <= emit ? rx : 32'sd0;
			o_z_q <= emit ? rz : 32'sd0;
			o_height_q <= emit ? rec_q[12] : 8'd0;
			o_prev_q <= emit ? rec_q[13] : 8'd0;
			o_next_q <= emit ? rec_q[14] : 8'd0;
			o_rec_q <= emit;
			o_done_q <= last_s1;
			o_verdict_q <= last_s1 ? verdict : elsc_pkg::V_OK;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.rec_tick = o_tick_q;
	assign out_ch.rec_x = o_x_q;
	assign out_ch.rec_z = o_z_q;
	assign out_ch.rec_height = o_height_q;
	assign out_ch.rec_prev_block = o_prev_q;
	assign out_ch.rec_next_block = o_next_q;
	assign out_ch.record_ready = o_rec_q;
	assign out_ch.stream_done = o_done_q;
	assign out_ch.verdict = o_verdict_q;

	// every result carries a record, a verdict or both
	`ELSC_ASSERT_IMPLY(a_result_nonempty, out_valid_q, o_rec_q || o_done_q)
	// a verdict code only rides with the end of a stream
	`ELSC_ASSERT_IMPLY(a_verdict_only_done, out_valid_q && !o_done_q, o_verdict_q == elsc_pkg::V_OK)
	// an emitted record never has a zero tick
	`ELSC_ASSERT_IMPLY(a_rec_tick_nonzero, out_valid_q && o_rec_q, o_tick_q != 32'd0)
	// the final byte restarts the stream
	`ELSC_ASSERT_NEXT(a_stream_restart, adv_s1 && last_s1, pos_q == '0 && crc_q == 32'hFFFF_FFFF)

endmodule
